// ===== hdl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers for the checker file apst_checker.sv.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== hdl/apst_pkg.sv =====
// ---------------------------------------------------------------------------
// apst_pkg
// Types and constants of the address pool slot table.
// ---------------------------------------------------------------------------
package apst_pkg;

   localparam int SLOT_W     = 8;
   localparam int PREFIX_W   = 24;
   localparam int HANDLE_W   = 16;
   localparam int TIME_W     = 32;
   localparam int ADDR_W     = 32;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic CSR_IDX_PREFIX = 1'b0;

   typedef enum logic [2:0] {
      ACT_ALLOC     = 3'd0,
      ACT_RELEASE   = 3'd1,
      ACT_FIND_HDL  = 3'd2,
      ACT_FIND_ADDR = 3'd3,
      ACT_HEARTBEAT = 3'd4
   } action_type;

   typedef enum logic {
      ST_IDLE,
      ST_SCAN
   } state_type;

   typedef struct packed {
      logic [2:0]          action;
      logic [HANDLE_W-1:0] handle;
      logic [ADDR_W-1:0]   lookup_address;
      logic [TIME_W-1:0]   now_secs;
   } req_type;

   typedef struct packed {
      logic                ok;
      logic [SLOT_W-1:0]   slot;
      logic [ADDR_W-1:0]   assigned_address;
   } rsp_type;

   typedef struct packed {
      logic [HANDLE_W-1:0] owner;
      logic [TIME_W-1:0]   sent_time;
      logic [TIME_W-1:0]   recv_time;
   } entry_type;

endpackage

// ===== hdl/address_pool_slot_table_top.sv =====
// ---------------------------------------------------------------------------
// address_pool_slot_table_top
// First-free address pool: allocate, release, lookup and heartbeat on a
// table of slots kept in one synchronous memory.
// ---------------------------------------------------------------------------
// Usage:
//   Command channel: drive req_data and raise start; the word is taken at
//   the clock edge where start is high and busy is low. busy stays high
//   while the table is scanned.
//   Result channel: rsp_strobe is high for exactly one cycle with rsp_data;
//   every command yields one result word. The receiver cannot stall.
//   The scan reads one slot per cycle through the registered read of
//   the table memory and stops at the first hit. busy falls in the cycle
//   in which rsp_strobe rises, so a new command is taken at the edge ending
//   the strobe cycle; no command is taken before the last one has its result.
//   The whole table is scanned when there is no hit (pool full or unknown
//   action).
//   Configuration: APB register 0 (byte address 0) holds the 24-bit
//   address prefix; write it only while busy is low and no result pends.
//   Reset: synchronous; frees all slots except 0, 1 and SLOTS-1, clears the
//   prefix. Slot contents need no clearing pass.
// ---------------------------------------------------------------------------
module address_pool_slot_table_top #(
   parameter int SLOTS = 256
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  apst_pkg::req_type                  req_data,
   output logic                               rsp_strobe,
   output apst_pkg::rsp_type                  rsp_data,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [apst_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [apst_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [apst_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                               pready
);

   localparam int IDX_W = $clog2(SLOTS);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);
   localparam logic [SLOTS-1:0] IN_USE_RESET =
      (SLOTS'(1) << (SLOTS - 1)) | SLOTS'(3);

   apst_pkg::state_type                 state_ff, state_in;
   apst_pkg::req_type                   req_ff, req_in;
   logic [IDX_W-1:0]                    rd_idx_ff, rd_idx_in;
   logic                                rd_more_ff, rd_more_in;
   logic                                cmp_vld_ff, cmp_vld_in;
   logic [IDX_W-1:0]                    cmp_idx_ff;
   apst_pkg::entry_type                 ent_rd_ff;
   logic [SLOTS-1:0]                    in_use_ff, in_use_in;
   logic [SLOTS-1:0]                    owned_ff, owned_in;
   logic [apst_pkg::PREFIX_W-1:0]       prefix_ff, prefix_in;
   logic                                rsp_strobe_ff, rsp_strobe_in;
   apst_pkg::rsp_type                   rsp_data_ff, rsp_data_in;

   apst_pkg::entry_type                 ent_mem [SLOTS];
   logic                                wr_en;
   apst_pkg::entry_type                 wr_data;

   logic [apst_pkg::SLOT_W-1:0]         cmp_slot;
   logic [apst_pkg::ADDR_W-1:0]         cmp_addr;
   logic                                owner_hit;
   logic                                addr_hit;
   logic                                hit;
   logic                                done;
   logic                                csr_wr;

   assign cmp_slot  = apst_pkg::SLOT_W'(cmp_idx_ff);
   assign cmp_addr  = {prefix_ff, cmp_slot};
   assign owner_hit = owned_ff[cmp_idx_ff] && (ent_rd_ff.owner == req_ff.handle);
   assign addr_hit  = owned_ff[cmp_idx_ff] && (cmp_addr == req_ff.lookup_address);

   always_comb begin
      unique case (req_ff.action)
         apst_pkg::ACT_ALLOC:     hit = !in_use_ff[cmp_idx_ff];
         apst_pkg::ACT_RELEASE:   hit = owner_hit;
         apst_pkg::ACT_FIND_HDL:  hit = owner_hit;
         apst_pkg::ACT_FIND_ADDR: hit = addr_hit;
         apst_pkg::ACT_HEARTBEAT: hit = owner_hit;
         default:                 hit = 1'b0;
      endcase
   end

   assign done   = (state_ff == apst_pkg::ST_SCAN) && cmp_vld_ff
                   && (hit || (cmp_idx_ff == LAST_IDX));
   assign csr_wr = psel && penable && pwrite && pready
                   && (paddr[2] == apst_pkg::CSR_IDX_PREFIX);

   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      rd_idx_in     = rd_idx_ff;
      rd_more_in    = rd_more_ff;
      cmp_vld_in    = 1'b0;
      in_use_in     = in_use_ff;
      owned_in      = owned_ff;
      prefix_in     = csr_wr ? pwdata[apst_pkg::PREFIX_W-1:0] : prefix_ff;
      rsp_strobe_in = 1'b0;
      rsp_data_in   = rsp_data_ff;
      wr_en         = 1'b0;
      wr_data       = ent_rd_ff;

      unique case (state_ff)
         apst_pkg::ST_IDLE: begin
            if (start) begin
               req_in     = req_data;
               rd_idx_in  = '0;
               rd_more_in = 1'b1;
               state_in   = apst_pkg::ST_SCAN;
            end
         end
         apst_pkg::ST_SCAN: begin
            // issue the next read while comparing the previous one
            cmp_vld_in = rd_more_ff;
            if (rd_more_ff) begin
               if (rd_idx_ff == LAST_IDX) begin
                  rd_more_in = 1'b0;
               end else begin
                  rd_idx_in = rd_idx_ff + IDX_W'(1);
               end
            end
            if (done) begin
               state_in      = apst_pkg::ST_IDLE;
               cmp_vld_in    = 1'b0;
               rsp_strobe_in = 1'b1;
               if (hit) begin
                  rsp_data_in.ok               = 1'b1;
                  rsp_data_in.slot             = cmp_slot;
                  rsp_data_in.assigned_address = cmp_addr;
               end else begin
                  rsp_data_in = '0;
               end
               if (hit) begin
                  unique case (req_ff.action)
                     apst_pkg::ACT_ALLOC: begin
                        in_use_in[cmp_idx_ff] = 1'b1;
                        owned_in[cmp_idx_ff]  = 1'b1;
                        wr_en                 = 1'b1;
                        wr_data.owner         = req_ff.handle;
                        wr_data.sent_time     = req_ff.now_secs;
                        wr_data.recv_time     = req_ff.now_secs;
                     end
                     apst_pkg::ACT_RELEASE: begin
                        in_use_in[cmp_idx_ff] = 1'b0;
                        owned_in[cmp_idx_ff]  = 1'b0;
                     end
                     apst_pkg::ACT_HEARTBEAT: begin
                        wr_en             = 1'b1;
                        wr_data.recv_time = req_ff.now_secs;
                     end
                     default: begin
                     end
                  endcase
               end
            end
         end
         default: begin
            state_in = apst_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= apst_pkg::ST_IDLE;
         rd_more_ff    <= 1'b0;
         cmp_vld_ff    <= 1'b0;
         in_use_ff     <= IN_USE_RESET;
         owned_ff      <= '0;
         prefix_ff     <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rd_more_ff    <= rd_more_in;
         cmp_vld_ff    <= cmp_vld_in;
         in_use_ff     <= in_use_in;
         owned_ff      <= owned_in;
         prefix_ff     <= prefix_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      rd_idx_ff   <= rd_idx_in;
      cmp_idx_ff  <= rd_idx_ff;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         ent_mem[cmp_idx_ff] <= wr_data;
      end
      ent_rd_ff <= ent_mem[rd_idx_ff];
   end

   assign busy       = (state_ff != apst_pkg::ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;
   assign pready     = 1'b1;
   assign prdata     = (paddr[2] == apst_pkg::CSR_IDX_PREFIX)
                       ? apst_pkg::CSR_DATA_W'(prefix_ff) : '0;

endmodule

// ===== hdl/apst_checker.sv =====
// ---------------------------------------------------------------------------
// apst_checker
// Port-level checks of the address pool slot table, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module apst_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input apst_pkg::rsp_type rsp_data,
   input logic              rsp_strobe
);

   `ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)
   `ASSERT_IMPLY(a_strobe_idle, clock, reset, rsp_strobe, !busy)
   `ASSERT_IMPLY(a_fall_strobe, clock, reset, $fell(busy), rsp_strobe)
   `ASSERT_IMPLY(a_miss_zero, clock, reset, rsp_strobe && !rsp_data.ok, (rsp_data.slot == '0) && (rsp_data.assigned_address == '0))
   `ASSERT_IMPLY(a_hit_addr, clock, reset, rsp_strobe && rsp_data.ok, rsp_data.assigned_address[7:0] == rsp_data.slot)

endmodule

bind address_pool_slot_table_top apst_checker u_apst_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_data   (rsp_data),
   .rsp_strobe (rsp_strobe)
);
